FILE: rtl/lru_key_cache_controller_unit_defines.svh
// ----------------------------------------------------------------------------
// lru key cache assertion macros
// shared concurrent check forms used by the cache rtl
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_CACHE_CONTROLLER_UNIT_DEFINES_SVH
`define LRU_KEY_CACHE_CONTROLLER_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define LKC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lkc: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define LKC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lkc: next-cycle check failed");

`endif

FILE: rtl/lkc_pkg.sv
// ----------------------------------------------------------------------------
// lkc_pkg
// types and fixed widths shared by the lru key cache modules
// ----------------------------------------------------------------------------
package lkc_pkg;

  localparam int CFG_W      = 4;
  localparam int KEY_PORT_W = 32;
  localparam int SLOT_W     = 3;
  localparam int OCC_W      = 4;

  localparam logic [CFG_W-1:0] CAP_RESET = 4'd8;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_PROBE  = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE
  } seq_state_t;

  typedef struct packed {
    logic init;    // clear scan accumulators
    logic issue;   // read one slot this cycle
    logic commit;  // apply the operation
  } seq_ctl_t;

endpackage

FILE: rtl/lkc_seq.sv
// ----------------------------------------------------------------------------
// lkc_seq
// sequencer: walks the slots one per cycle, then commits the operation
// ----------------------------------------------------------------------------
module lkc_seq #(
  parameter int DEPTH = 8,
  parameter int IDX_W = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output lkc_pkg::seq_ctl_t  ctl,
  output logic [IDX_W-1:0]   rd_idx
);
  import lkc_pkg::*;

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(DEPTH - 1);

  seq_state_t       state, state_next;
  logic [IDX_W-1:0] idx, idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    ctl        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          ctl.init   = 1'b1;
          idx_next   = '0;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctl.issue = 1'b1;
        if (idx == LastIdx) begin
          state_next = ST_DRAIN;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      // last compare lands here
      ST_DRAIN: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        ctl.commit = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy   = (state != ST_IDLE);
  assign rd_idx = idx;

endmodule

FILE: rtl/lkc_scan.sv
// ----------------------------------------------------------------------------
// lkc_scan
// key store and the shared slot compare unit, one slot per cycle
// ----------------------------------------------------------------------------
module lkc_scan #(
  parameter int DEPTH  = 8,
  parameter int IDX_W  = 3,
  parameter int KEY_W  = 32,
  parameter int RANK_W = 3,
  parameter int CNT_W  = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  lkc_pkg::seq_ctl_t ctl,
  input  logic [IDX_W-1:0]  rd_idx,
  input  logic [KEY_W-1:0]  key_ref,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_idx,
  input  logic [KEY_W-1:0]  wr_key,
  output logic [IDX_W-1:0]  cmp_idx,
  input  logic              cmp_vld,
  input  logic [RANK_W-1:0] cmp_rank,
  output logic              found,
  output logic [IDX_W-1:0]  found_idx,
  output logic [RANK_W-1:0] found_rank,
  output logic              free_seen,
  output logic [IDX_W-1:0]  free_idx,
  output logic              lru_seen,
  output logic [IDX_W-1:0]  lru_idx,
  output logic [KEY_W-1:0]  lru_key,
  output logic [CNT_W-1:0]  occ
);

  logic [KEY_W-1:0]  key_mem [DEPTH];
  logic [KEY_W-1:0]  key_rd;
  logic              cmp_en;
  logic [RANK_W-1:0] lru_rank;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_idx] <= wr_key;
    end
    key_rd  <= key_mem[rd_idx];
    cmp_idx <= rd_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_en    <= 1'b0;
      found     <= 1'b0;
      free_seen <= 1'b0;
      lru_seen  <= 1'b0;
      occ       <= '0;
    end else begin
      cmp_en <= ctl.issue;
      if (ctl.init) begin
        found     <= 1'b0;
        free_seen <= 1'b0;
        lru_seen  <= 1'b0;
        occ       <= '0;
      end else if (cmp_en) begin
        if (cmp_vld) begin
          occ <= occ + 1'b1;
          if (!found && key_rd == key_ref) begin
            found <= 1'b1;
          end
          if (!lru_seen || cmp_rank > lru_rank) begin
            lru_seen <= 1'b1;
          end
        end else if (!free_seen) begin
          free_seen <= 1'b1;
        end
      end
    end
  end

  // payload side of the tracking registers
  always_ff @(posedge clk) begin
    if (cmp_en) begin
      if (cmp_vld) begin
        if (!found && key_rd == key_ref) begin
          found_idx  <= cmp_idx;
          found_rank <= cmp_rank;
        end
        if (!lru_seen || cmp_rank > lru_rank) begin
          lru_idx  <= cmp_idx;
          lru_rank <= cmp_rank;
          lru_key  <= key_rd;
        end
      end else if (!free_seen) begin
        free_idx <= cmp_idx;
      end
    end
  end

endmodule

FILE: rtl/lru_key_cache_controller_unit.sv
// ----------------------------------------------------------------------------
// lru_key_cache_controller_unit
// fully associative least-recently-used key cache with eviction report
// ----------------------------------------------------------------------------
// usage:
//   command channel: drive mode and key and raise start; the command is
//   taken at a rising edge with start high and busy low. busy stays high
//   while the command runs.
//   result channel: done pulses for one cycle with hit, slot, evicted,
//   evicted_key and occupancy. the receiver cannot stall, so it must take
//   the result in that cycle.
//   config channel: cfg_data (capacity in use) is written on a transfer
//   with cfg_valid and cfg_ready high; cfg_ready is always high. write it
//   only while no command is in flight.
// timing:
//   a command walks the key store one slot per cycle through one key and
//   rank comparator, then commits. done rises after the scan, a drain
//   state and the commit state. a new command is taken only once the
//   sequencer is idle again, as the key store has a single read port.
// reset:
//   rst (synchronous) empties the cache, sets capacity in use to 8 and
//   returns the sequencer to idle. key store contents are not cleared.
// ----------------------------------------------------------------------------
`include "lru_key_cache_controller_unit_defines.svh"

module lru_key_cache_controller_unit #(
  parameter int CAPACITY_MAX = 8,
  parameter int KEY_BITS     = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [31:0] key,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  output logic        done,
  output logic        hit,
  output logic [2:0]  slot,
  output logic        evicted,
  output logic [31:0] evicted_key,
  output logic [3:0]  occupancy
);
  import lkc_pkg::*;

  localparam int IDX_W  = $clog2(CAPACITY_MAX);
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(CAPACITY_MAX + 1);
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // configuration
  logic [CFG_W-1:0] capacity;
  logic [CMP_W-1:0] cap_w, cap_eff, occ_w;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  always_comb begin
    cap_w = CMP_W'(capacity);
    if (cap_w == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_w > CMP_W'(CAPACITY_MAX)) begin
      cap_eff = CMP_W'(CAPACITY_MAX);
    end else begin
      cap_eff = cap_w;
    end
  end

  // command capture
  logic              accept;
  op_mode_t          op_mode;
  logic [KEY_BITS-1:0] op_key;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode <= op_mode_t'(mode);
      op_key  <= KEY_BITS'(key);
    end
  end

  // sequencer and scan unit
  seq_ctl_t          ctl;
  logic [IDX_W-1:0]  rd_idx, cmp_idx;
  logic              cmp_vld;
  logic [RANK_W-1:0] cmp_rank;
  logic              found, free_seen, lru_seen;
  logic [IDX_W-1:0]  found_idx, free_idx, lru_idx;
  logic [RANK_W-1:0] found_rank;
  logic [KEY_BITS-1:0] lru_key;
  logic [CNT_W-1:0]  occ;
  logic              wr_en;
  logic [IDX_W-1:0]  target;

  lkc_seq #(
    .DEPTH (CAPACITY_MAX),
    .IDX_W (IDX_W)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .ctl    (ctl),
    .rd_idx (rd_idx)
  );

  lkc_scan #(
    .DEPTH  (CAPACITY_MAX),
    .IDX_W  (IDX_W),
    .KEY_W  (KEY_BITS),
    .RANK_W (RANK_W),
    .CNT_W  (CNT_W)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .rd_idx     (rd_idx),
    .key_ref    (op_key),
    .wr_en      (wr_en),
    .wr_idx     (target),
    .wr_key     (op_key),
    .cmp_idx    (cmp_idx),
    .cmp_vld    (cmp_vld),
    .cmp_rank   (cmp_rank),
    .found      (found),
    .found_idx  (found_idx),
    .found_rank (found_rank),
    .free_seen  (free_seen),
    .free_idx   (free_idx),
    .lru_seen   (lru_seen),
    .lru_idx    (lru_idx),
    .lru_key    (lru_key),
    .occ        (occ)
  );

  // valid bits and recency ranks, rank 0 is most recent
  logic [CAPACITY_MAX-1:0] valid, valid_next;
  logic [RANK_W-1:0]       recency      [CAPACITY_MAX];
  logic [RANK_W-1:0]       recency_next [CAPACITY_MAX];

  assign cmp_vld  = valid[cmp_idx];
  assign cmp_rank = recency[cmp_idx];

  logic              evict, ins;
  logic              res_hit, res_evicted;
  logic [IDX_W-1:0]  res_slot;
  logic [CNT_W-1:0]  occ_next;

  assign occ_w  = CMP_W'(occ);
  assign evict  = (occ_w >= cap_eff) && lru_seen;
  assign ins    = evict || free_seen;
  assign target = evict ? lru_idx : free_idx;
  assign wr_en  = ctl.commit && (op_mode == OP_LOOKUP) && !found && ins;

  always_comb begin
    valid_next   = valid;
    recency_next = recency;
    res_hit      = 1'b0;
    res_slot     = '0;
    res_evicted  = 1'b0;
    occ_next     = occ;
    unique case (op_mode)
      OP_LOOKUP: begin
        if (found) begin
          res_hit  = 1'b1;
          res_slot = found_idx;
          for (int i = 0; i < CAPACITY_MAX; i++) begin
            if (valid[i] && IDX_W'(i) != found_idx && recency[i] < found_rank) begin
              recency_next[i] = recency[i] + 1'b1;
            end
          end
          recency_next[found_idx] = '0;
        end else if (ins) begin
          res_slot    = target;
          res_evicted = evict;
          // everything left ages by one, the evicted slot is reused
          for (int i = 0; i < CAPACITY_MAX; i++) begin
            if (valid[i] && !(evict && IDX_W'(i) == target)) begin
              recency_next[i] = recency[i] + 1'b1;
            end
          end
          valid_next[target]   = 1'b1;
          recency_next[target] = '0;
          if (!evict) begin
            occ_next = occ + 1'b1;
          end
        end
      end
      OP_PROBE: begin
        if (found) begin
          res_hit  = 1'b1;
          res_slot = found_idx;
        end
      end
      OP_REMOVE: begin
        if (found) begin
          res_hit  = 1'b1;
          res_slot = found_idx;
          for (int i = 0; i < CAPACITY_MAX; i++) begin
            if (valid[i] && recency[i] > found_rank) begin
              recency_next[i] = recency[i] - 1'b1;
            end
          end
          valid_next[found_idx]   = 1'b0;
          recency_next[found_idx] = '0;
          occ_next = occ - 1'b1;
        end
      end
      OP_CLEAR: begin
        valid_next = '0;
        for (int i = 0; i < CAPACITY_MAX; i++) begin
          recency_next[i] = '0;
        end
        occ_next = '0;
      end
      default: begin
        valid_next = valid;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      for (int i = 0; i < CAPACITY_MAX; i++) begin
        recency[i] <= '0;
      end
    end else if (ctl.commit) begin
      valid   <= valid_next;
      recency <= recency_next;
    end
  end

  // result register, one cycle strobe
  logic [CNT_W-1:0] occ_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      hit         <= res_hit;
      slot        <= SLOT_W'(res_slot);
      evicted     <= res_evicted;
      evicted_key <= res_evicted ? KEY_PORT_W'(lru_key) : '0;
      occ_out     <= occ_next;
    end
  end

  assign occupancy = OCC_W'(occ_out);

  `LKC_ASSERT_SAME(a_done_idle, clk, rst, done, !busy)
  `LKC_ASSERT_SAME(a_evict_miss, clk, rst, done && evicted, !hit)
  `LKC_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy)
  `LKC_ASSERT_SAME(a_occ_count, clk, rst, done, occ_out == $countones(valid))

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the lru key cache controller unit. a directed
// table covers the cache boundaries and capacity corner cases, then random
// phases with different capacities mix lookups, probes, removes and clears
// over a small key pool. every result is compared against an in-bench lru
// predictor, or for typed table rows against the row's expected result.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lkc_pkg::*;

  localparam int NSLOT       = 8;
  localparam int CYCLE_LIMIT = 300000;
  localparam int N_PHASES    = 11;
  localparam int PHASE_ITEMS = 100;
  localparam int N_PLAN      = 27;

  typedef struct packed {
    logic        hit;
    logic [2:0]  slot;
    logic        evicted;
    logic [31:0] evicted_key;
    logic [3:0]  occupancy;
  } cache_result_t;

  typedef struct {
    bit            is_cfg;
    logic [3:0]    cfg;
    op_mode_t      op;
    logic [31:0]   k;
    bit            typed;
    cache_result_t want;
  } plan_row_t;

  localparam cache_result_t NO_WANT = '0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  op_mode_t    cmd_mode = OP_LOOKUP;
  logic [31:0] cmd_key = 32'h0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_data = 4'd0;
  logic        done;
  logic        hit;
  logic [2:0]  slot;
  logic        evicted;
  logic [31:0] evicted_key;
  logic [3:0]  occupancy;

  // predictor state
  logic [31:0] line_key [NSLOT];
  bit          line_valid [NSLOT];
  int unsigned line_rank [NSLOT];
  logic [3:0]  cap_setting;

  cache_result_t pending_results [$];
  int cycles = 0;
  int n_bad = 0;
  int n_cmds = 0;
  int n_checked = 0;
  int n_hits = 0;
  int n_evicts = 0;
  int n_cfg = 0;

  plan_row_t plan [N_PLAN] = '{
    '{0, 4'd0, OP_PROBE,  32'h00000000, 1, '{1'b0, 3'd0, 1'b0, 32'h0, 4'd0}},
    '{0, 4'd0, OP_LOOKUP, 32'h00000000, 1, '{1'b0, 3'd0, 1'b0, 32'h0, 4'd1}},
    '{0, 4'd0, OP_LOOKUP, 32'hFFFFFFFF, 1, '{1'b0, 3'd1, 1'b0, 32'h0, 4'd2}},
    '{0, 4'd0, OP_LOOKUP, 32'h00000000, 1, '{1'b1, 3'd0, 1'b0, 32'h0, 4'd2}},
    '{0, 4'd0, OP_PROBE,  32'hFFFFFFFF, 1, '{1'b1, 3'd1, 1'b0, 32'h0, 4'd2}},
    '{0, 4'd0, OP_REMOVE, 32'h12345678, 1, '{1'b0, 3'd0, 1'b0, 32'h0, 4'd2}},
    '{0, 4'd0, OP_REMOVE, 32'hFFFFFFFF, 1, '{1'b1, 3'd1, 1'b0, 32'h0, 4'd1}},
    '{0, 4'd0, OP_LOOKUP, 32'hA5A5A5A5, 0, NO_WANT},
    '{0, 4'd0, OP_LOOKUP, 32'h5A5A5A5A, 0, NO_WANT},
    '{0, 4'd0, OP_LOOKUP, 32'h00000001, 0, NO_WANT},
    '{0, 4'd0, OP_LOOKUP, 32'h00000002, 0, NO_WANT},
    '{0, 4'd0, OP_LOOKUP, 32'h00000004, 0, NO_WANT},
    '{0, 4'd0, OP_LOOKUP, 32'h80000000, 0, NO_WANT},
    '{0, 4'd0, OP_LOOKUP, 32'h7FFFFFFF, 0, NO_WANT},
    // full cache: this miss evicts the oldest entry
    '{0, 4'd0, OP_LOOKUP, 32'hDEADBEEF, 0, NO_WANT},
    // shrink below occupancy, a miss replaces exactly one entry
    '{1, 4'd2, OP_LOOKUP, 32'h0,        0, NO_WANT},
    '{0, 4'd0, OP_LOOKUP, 32'h0F0F0F0F, 0, NO_WANT},
    '{0, 4'd0, OP_PROBE,  32'hA5A5A5A5, 0, NO_WANT},
    // zero capacity acts as one
    '{1, 4'd0, OP_LOOKUP, 32'h0,        0, NO_WANT},
    '{0, 4'd0, OP_LOOKUP, 32'h00000003, 0, NO_WANT},
    '{0, 4'd0, OP_CLEAR,  32'h00000000, 1, '{1'b0, 3'd0, 1'b0, 32'h0, 4'd0}},
    '{0, 4'd0, OP_LOOKUP, 32'h00000005, 1, '{1'b0, 3'd0, 1'b0, 32'h0, 4'd1}},
    '{0, 4'd0, OP_LOOKUP, 32'h00000006, 1, '{1'b0, 3'd0, 1'b1, 32'h5, 4'd1}},
    '{0, 4'd0, OP_REMOVE, 32'h00000006, 1, '{1'b1, 3'd0, 1'b0, 32'h0, 4'd0}},
    // above the maximum acts as the maximum
    '{1, 4'd15, OP_LOOKUP, 32'h0,       0, NO_WANT},
    '{0, 4'd0, OP_LOOKUP, 32'hF0F0F0F0, 0, NO_WANT},
    '{1, 4'd8, OP_LOOKUP, 32'h0,        0, NO_WANT}
  };

  lru_key_cache_controller_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (cmd_mode),
    .key         (cmd_key),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .done        (done),
    .hit         (hit),
    .slot        (slot),
    .evicted     (evicted),
    .evicted_key (evicted_key),
    .occupancy   (occupancy)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int valid_count();
    int i;
    int n;
    n = 0;
    for (i = 0; i < NSLOT; i++)
      if (line_valid[i]) n++;
    return n;
  endfunction

  // applies one command to the predicted cache and returns its result
  function automatic cache_result_t lru_predict(op_mode_t op, logic [31:0] k);
    cache_result_t r;
    int i;
    int found;
    int victim;
    int unsigned top;
    int cap;
    r = '0;
    cap = int'(cap_setting);
    if (cap < 1) cap = 1;
    if (cap > NSLOT) cap = NSLOT;
    found = -1;
    for (i = 0; i < NSLOT; i++)
      if (found < 0 && line_valid[i] && line_key[i] == k) found = i;
    case (op)
      OP_LOOKUP: begin
        if (found >= 0) begin
          r.hit = 1'b1;
          r.slot = found[2:0];
          top = line_rank[found];
          for (i = 0; i < NSLOT; i++)
            if (line_valid[i] && i != found && line_rank[i] < top) line_rank[i]++;
          line_rank[found] = 0;
        end else begin
          victim = -1;
          top = 0;
          if (valid_count() >= cap) begin
            for (i = 0; i < NSLOT; i++)
              if (line_valid[i] && (victim < 0 || line_rank[i] > top)) begin
                victim = i;
                top = line_rank[i];
              end
            if (victim >= 0) begin
              r.evicted = 1'b1;
              r.evicted_key = line_key[victim];
              line_valid[victim] = 1'b0;
            end
          end
          if (victim < 0) begin
            for (i = NSLOT - 1; i >= 0; i--)
              if (!line_valid[i]) victim = i;
          end
          if (victim >= 0) begin
            for (i = 0; i < NSLOT; i++)
              if (line_valid[i]) line_rank[i]++;
            line_key[victim] = k;
            line_valid[victim] = 1'b1;
            line_rank[victim] = 0;
            r.slot = victim[2:0];
          end
        end
      end
      OP_PROBE: begin
        if (found >= 0) begin
          r.hit = 1'b1;
          r.slot = found[2:0];
        end
      end
      OP_REMOVE: begin
        if (found >= 0) begin
          top = line_rank[found];
          r.hit = 1'b1;
          r.slot = found[2:0];
          line_valid[found] = 1'b0;
          line_rank[found] = 0;
          for (i = 0; i < NSLOT; i++)
            if (line_valid[i] && line_rank[i] > top) line_rank[i]--;
        end
      end
      default: begin
        for (i = 0; i < NSLOT; i++) begin
          line_valid[i] = 1'b0;
          line_rank[i] = 0;
        end
      end
    endcase
    r.occupancy = 4'(valid_count());
    return r;
  endfunction

  // mostly back to back or short, now and then a long gap
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  task automatic issue(op_mode_t op, logic [31:0] k, int gap, bit typed,
                       cache_result_t want);
    cache_result_t r;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd_mode <= op;
    cmd_key <= k;
    do @(posedge clk); while (busy);
    r = lru_predict(op, k);
    if (typed) r = want;
    if (r.hit) n_hits++;
    if (r.evicted) n_evicts++;
    n_cmds++;
    pending_results = {pending_results, r};
  endtask

  // stop sending and let every outstanding result come back
  task automatic settle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_capacity(logic [3:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_setting = v;
    n_cfg++;
  endtask

  always @(posedge clk) begin
    cache_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no command outstanding");
        n_bad++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, hit);
          n_bad++;
        end
        if (slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, slot);
          n_bad++;
        end
        if (evicted !== want.evicted) begin
          $error("evicted: expected %0d, got %0d", want.evicted, evicted);
          n_bad++;
        end
        if (evicted_key !== want.evicted_key) begin
          $error("evicted_key: expected %h, got %h", want.evicted_key, evicted_key);
          n_bad++;
        end
        if (occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy);
          n_bad++;
        end
      end
    end
  end

  initial begin
    logic [31:0] key_pool [16];
    int pool_n;
    int p;
    int j;
    int r;
    int eff;
    bit no_idle;
    op_mode_t op;
    logic [31:0] k;
    logic [3:0] phase_cap;

    for (j = 0; j < NSLOT; j++) begin
      line_key[j] = 32'h0;
      line_valid[j] = 1'b0;
      line_rank[j] = 0;
    end
    cap_setting = CAP_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (j = 0; j < N_PLAN; j++) begin
      if (plan[j].is_cfg)
        write_capacity(plan[j].cfg);
      else
        issue(plan[j].op, plan[j].k, pick_gap(), plan[j].typed, plan[j].want);
    end

    for (p = 0; p < N_PHASES; p++) begin
      case (p)
        0: phase_cap = 4'd15;
        1: phase_cap = 4'd1;
        2: phase_cap = 4'd0;
        3: phase_cap = 4'd8;
        4: phase_cap = 4'd3;
        default: phase_cap = 4'($urandom_range(0, 15));
      endcase
      write_capacity(phase_cap);
      eff = (phase_cap < 1) ? 1 : (phase_cap > NSLOT) ? NSLOT : phase_cap;
      // a pool up to five keys larger than the capacity keeps hits and misses mixed
      pool_n = eff + $urandom_range(0, 5);
      for (j = 0; j < pool_n; j++) begin
        r = $urandom_range(0, 19);
        key_pool[j] = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFFFFFF : $urandom;
      end
      no_idle = ($urandom_range(0, 3) == 0);
      for (j = 0; j < PHASE_ITEMS; j++) begin
        r = $urandom_range(0, 99);
        if (r < 58) op = OP_LOOKUP;
        else if (r < 73) op = OP_PROBE;
        else if (r < 88) op = OP_REMOVE;
        else if (r < 91) op = OP_CLEAR;
        else op = op_mode_t'($urandom_range(0, 3));
        if (r >= 91 || $urandom_range(0, 9) == 0)
          k = $urandom;
        else
          k = key_pool[$urandom_range(0, pool_n - 1)];
        if ($urandom_range(0, 49) == 0) settle();
        issue(op, k, no_idle ? 0 : pick_gap(), 1'b0, NO_WANT);
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    $display("covered %0d commands, %0d results checked, %0d capacity writes",
             n_cmds, n_checked, n_cfg);
    $display("predicted %0d hits and %0d evictions", n_hits, n_evicts);
    if (n_bad == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
